// ===== hdl/dar_pkg.sv =====
// Package for the direction auto-repeat block: widths, register indexes, reset values.
package dar_pkg;

  localparam int unsigned CHANNEL_SLOTS_DEF = 5;
  localparam int unsigned DIRECTIONS_DEF    = 4;

  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned STICK_W  = 9;
  localparam int unsigned STICK2_W = 17;
  localparam int unsigned FRAME_W  = 32;
  localparam int unsigned TICKS_W  = 64;
  localparam int unsigned DELAY_W  = 32;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned THR2_W   = 16;

  localparam int unsigned IN_BITS   = CHAN_W + DIR_W + 2 + STICK_W + STICK2_W + FRAME_W + TICKS_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = 8;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FIRST_DELAY    = 3'd0,
    REG_REPEAT_IVL     = 3'd1,
    REG_PAD_THR        = 3'd2,
    REG_PAD_REL_THR    = 3'd3,
    REG_PAD2_THR       = 3'd4,
    REG_PAD2_REL_THR   = 3'd5
  } cfg_reg_t;

  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = 32'd24300000;
  localparam logic [DELAY_W-1:0] REPEAT_IVL_RST   = 32'd8505000;
  localparam logic [THR_W-1:0]   PAD_THR_RST      = 8'd50;
  localparam logic [THR_W-1:0]   PAD_REL_THR_RST  = 8'd35;
  localparam logic [THR2_W-1:0]  PAD2_THR_RST     = 16'd20;
  localparam logic [THR2_W-1:0]  PAD2_REL_THR_RST = 16'd14;
  localparam logic [FRAME_W-1:0] FRAME_RST        = '1;

endpackage

// ===== hdl/direction_auto_repeat_hysteresis_top.sv =====
// Direction auto-repeat with stick hysteresis: top level.
// Path from input transaction to result transaction: input register, then result register; a
// stalled output holds the result register and, behind it, the input register.
// Throughput: one transaction per cycle unless the output stalls; each new-frame request does
// one read-modify-write of its slot/direction entry in a flop-based state file.
// Reset (rst_n low, synchronous): state entries cleared, answered frames set to all ones,
// configuration registers back to their defaults, both pipeline stages emptied.
module direction_auto_repeat_hysteresis_top #(
  parameter int unsigned CHANNEL_SLOTS = dar_pkg::CHANNEL_SLOTS_DEF,
  parameter int unsigned DIRECTIONS    = dar_pkg::DIRECTIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata, low bit up: channel_slot[3], direction[2], pressed_edge[1], button_held[1],
  //   stick_push[9], pad2_stick_push[17], frame_number[32], now_ticks[64], zero fill
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dar_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata, low bit up: step[1], zero fill
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dar_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [dar_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [dar_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned ENTRIES = CHANNEL_SLOTS * DIRECTIONS;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // configuration
  logic [dar_pkg::DELAY_W-1:0] first_delay_r, repeat_ivl_r;
  logic [dar_pkg::THR_W-1:0]   pad_thr_r, pad_rel_thr_r;
  logic [dar_pkg::THR2_W-1:0]  pad2_thr_r, pad2_rel_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r  <= dar_pkg::FIRST_DELAY_RST;
      repeat_ivl_r   <= dar_pkg::REPEAT_IVL_RST;
      pad_thr_r      <= dar_pkg::PAD_THR_RST;
      pad_rel_thr_r  <= dar_pkg::PAD_REL_THR_RST;
      pad2_thr_r     <= dar_pkg::PAD2_THR_RST;
      pad2_rel_thr_r <= dar_pkg::PAD2_REL_THR_RST;
    end else if (cfg_we) begin
      case (dar_pkg::cfg_reg_t'(cfg_addr))
        dar_pkg::REG_FIRST_DELAY:  first_delay_r  <= cfg_wdata;
        dar_pkg::REG_REPEAT_IVL:   repeat_ivl_r   <= cfg_wdata;
        dar_pkg::REG_PAD_THR:      pad_thr_r      <= cfg_wdata[dar_pkg::THR_W-1:0];
        dar_pkg::REG_PAD_REL_THR:  pad_rel_thr_r  <= cfg_wdata[dar_pkg::THR_W-1:0];
        dar_pkg::REG_PAD2_THR:     pad2_thr_r     <= cfg_wdata[dar_pkg::THR2_W-1:0];
        dar_pkg::REG_PAD2_REL_THR: pad2_rel_thr_r <= cfg_wdata[dar_pkg::THR2_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                          s1_valid_r;
  logic [IDX_W-1:0]              s1_idx_r;
  logic                          s1_pressed_r, s1_held_r;
  logic signed [dar_pkg::STICK_W-1:0]  s1_stick_r;
  logic signed [dar_pkg::STICK2_W-1:0] s1_stick2_r;
  logic [dar_pkg::FRAME_W-1:0]   s1_frame_r;
  logic [dar_pkg::TICKS_W-1:0]   s1_now_r;

  logic out_valid_r, out_step_r;
  logic advance, in_fire, s1_fire;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign s1_fire   = s1_valid_r && advance;

  // entry index from the incoming transaction
  logic [dar_pkg::CHAN_W-1:0] in_chan;
  logic [dar_pkg::DIR_W-1:0]  in_dir;
  logic [7:0] slot8, dir8, idx8;

  assign in_chan = in_tdata[2:0];
  assign in_dir  = in_tdata[4:3];

  always_comb begin
    slot8 = ({5'd0, in_chan} < 8'(CHANNEL_SLOTS - 1)) ? {5'd0, in_chan} : 8'(CHANNEL_SLOTS - 1);
    dir8  = ({6'd0, in_dir} >= 8'(DIRECTIONS)) ? 8'(DIRECTIONS - 1) : {6'd0, in_dir};
    idx8  = 8'(slot8 * 8'(DIRECTIONS)) + dir8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r     <= idx8[IDX_W-1:0];
      s1_pressed_r <= in_tdata[5];
      s1_held_r    <= in_tdata[6];
      s1_stick_r   <= in_tdata[15:7];
      s1_stick2_r  <= in_tdata[32:16];
      s1_frame_r   <= in_tdata[64:33];
      s1_now_r     <= in_tdata[128:65];
    end
  end

  // per-entry state
  logic                        hold_r       [ENTRIES];
  logic                        stick_hold_r [ENTRIES];
  logic [dar_pkg::TICKS_W-1:0] due_r        [ENTRIES];
  logic [dar_pkg::FRAME_W-1:0] frame_r      [ENTRIES];
  logic                        cached_r     [ENTRIES];

  logic                        cur_hold, cur_stick_hold, cur_cached, hit;
  logic [dar_pkg::TICKS_W-1:0] cur_due;
  logic signed [dar_pkg::THR_W+1:0]  line;
  logic signed [dar_pkg::THR2_W+1:0] line2;
  logic by_stick, step_nxt, due_we, hold_nxt, stick_hold_nxt;
  logic [dar_pkg::TICKS_W-1:0] due_nxt;

  always_comb begin
    cur_hold       = hold_r[s1_idx_r];
    cur_stick_hold = stick_hold_r[s1_idx_r];
    cur_due        = due_r[s1_idx_r];
    cur_cached     = cached_r[s1_idx_r];
    hit            = (frame_r[s1_idx_r] == s1_frame_r);

    line  = $signed({2'b00, (cur_stick_hold ? pad_rel_thr_r : pad_thr_r)});
    line2 = $signed({2'b00, (cur_stick_hold ? pad2_rel_thr_r : pad2_thr_r)});
    by_stick = ($signed({s1_stick_r[dar_pkg::STICK_W-1], s1_stick_r}) > line) ||
               ($signed({s1_stick2_r[dar_pkg::STICK2_W-1], s1_stick2_r}) > line2);

    step_nxt = 1'b0;
    due_we   = 1'b0;
    due_nxt  = s1_now_r + {32'd0, first_delay_r};
    priority if (s1_pressed_r) begin
      step_nxt = 1'b1;
      due_we   = 1'b1;
    end else if (s1_held_r || by_stick) begin
      if (!cur_hold) begin
        step_nxt = 1'b1;
        due_we   = 1'b1;
      end else if (s1_now_r >= cur_due) begin
        step_nxt = 1'b1;
        due_we   = 1'b1;
        due_nxt  = s1_now_r + {32'd0, repeat_ivl_r};
      end
    end else begin
      step_nxt = 1'b0;
    end
    hold_nxt       = s1_pressed_r || s1_held_r || by_stick;
    stick_hold_nxt = by_stick && !s1_held_r && !s1_pressed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        hold_r[i]       <= 1'b0;
        stick_hold_r[i] <= 1'b0;
        due_r[i]        <= '0;
        frame_r[i]      <= dar_pkg::FRAME_RST;
        cached_r[i]     <= 1'b0;
      end
    end else if (s1_fire && !hit) begin
      hold_r[s1_idx_r]       <= hold_nxt;
      stick_hold_r[s1_idx_r] <= stick_hold_nxt;
      frame_r[s1_idx_r]      <= s1_frame_r;
      cached_r[s1_idx_r]     <= step_nxt;
      if (due_we) begin
        due_r[s1_idx_r] <= due_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_step_r <= hit ? cur_cached : step_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(dar_pkg::OUT_DATA_W-1){1'b0}}, out_step_r};

  // checks
  a_press_steps: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !hit && s1_pressed_r |=> out_step_r)
    else $error("new press did not step");

  a_cache_hit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && hit |=> out_step_r == $past(cur_cached))
    else $error("same-frame request did not return cached answer");

  a_frame_recorded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> frame_r[$past(s1_idx_r)] == $past(s1_frame_r))
    else $error("answered frame not recorded");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled with room in the pipeline");

  a_stick_hold_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !hit && (s1_held_r || s1_pressed_r) |=> !stick_hold_r[$past(s1_idx_r)])
    else $error("stick hold set while button active");

endmodule

// ===== bench/dar_step_checker.sv =====
// Checker for the direction auto-repeat block: predicts each step decision and compares results.
module dar_step_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [dar_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [dar_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [dar_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dar_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             steps_waiting,
  output int                             results_checked,
  output int                             steps_seen
);

  localparam int ENTRIES = int'(dar_pkg::CHANNEL_SLOTS_DEF * dar_pkg::DIRECTIONS_DEF);
  localparam int LAST_SLOT = int'(dar_pkg::CHANNEL_SLOTS_DEF) - 1;
  localparam int DIRS = int'(dar_pkg::DIRECTIONS_DEF);

  typedef struct packed {
    logic [dar_pkg::TICKS_W-1:0]  now_ticks;
    logic [dar_pkg::FRAME_W-1:0]  frame;
    logic [dar_pkg::STICK2_W-1:0] stick2;
    logic [dar_pkg::STICK_W-1:0]  stick;
    logic                         held;
    logic                         pressed;
    logic [dar_pkg::DIR_W-1:0]    dir;
    logic [dar_pkg::CHAN_W-1:0]   chan;
  } request_t;

  logic [dar_pkg::DELAY_W-1:0] first_delay;
  logic [dar_pkg::DELAY_W-1:0] repeat_ivl;
  logic [dar_pkg::THR_W-1:0]   pad_thr;
  logic [dar_pkg::THR_W-1:0]   pad_rel;
  logic [dar_pkg::THR2_W-1:0]  pad2_thr;
  logic [dar_pkg::THR2_W-1:0]  pad2_rel;

  bit                          holding [ENTRIES];
  bit                          stick_holding [ENTRIES];
  logic [dar_pkg::TICKS_W-1:0] due_at [ENTRIES];
  logic [dar_pkg::FRAME_W-1:0] frame_seen [ENTRIES];
  bit                          answer_cache [ENTRIES];

  bit pending_steps [$];

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] STEP MISMATCH: %s", $realtime, what);
  endtask

  task automatic clear_state();
    first_delay = dar_pkg::FIRST_DELAY_RST;
    repeat_ivl  = dar_pkg::REPEAT_IVL_RST;
    pad_thr     = dar_pkg::PAD_THR_RST;
    pad_rel     = dar_pkg::PAD_REL_THR_RST;
    pad2_thr    = dar_pkg::PAD2_THR_RST;
    pad2_rel    = dar_pkg::PAD2_REL_THR_RST;
    for (int i = 0; i < ENTRIES; i++) begin
      holding[i]       = 1'b0;
      stick_holding[i] = 1'b0;
      due_at[i]        = '0;
      frame_seen[i]    = dar_pkg::FRAME_RST;
      answer_cache[i]  = 1'b0;
    end
    pending_steps.delete();
  endtask

  function automatic bit typematic_step(input request_t r);
    int slot, idx, line, line2;
    bit by_stick, fire;
    slot = (int'(r.chan) < LAST_SLOT) ? int'(r.chan) : LAST_SLOT;
    idx  = slot * DIRS + int'(r.dir);
    if (frame_seen[idx] == r.frame) return answer_cache[idx];
    line     = stick_holding[idx] ? int'(pad_rel) : int'(pad_thr);
    line2    = stick_holding[idx] ? int'(pad2_rel) : int'(pad2_thr);
    by_stick = (int'($signed(r.stick)) > line) || (int'($signed(r.stick2)) > line2);
    fire = 1'b0;
    if (r.pressed) begin
      fire = 1'b1;
      due_at[idx] = r.now_ticks + {32'd0, first_delay};
    end else if (r.held || by_stick) begin
      if (!holding[idx]) begin
        fire = 1'b1;
        due_at[idx] = r.now_ticks + {32'd0, first_delay};
      end else if (r.now_ticks >= due_at[idx]) begin
        fire = 1'b1;
        due_at[idx] = r.now_ticks + {32'd0, repeat_ivl};
      end
    end
    holding[idx]       = r.pressed || r.held || by_stick;
    stick_holding[idx] = by_stick && !r.held && !r.pressed;
    frame_seen[idx]    = r.frame;
    answer_cache[idx]  = fire;
    return fire;
  endfunction

  always @(posedge clk) begin
    bit want;
    if (!rst_n) begin
      clear_state();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_steps.size() == 0) begin
          report_mismatch($sformatf("result step=%0b with no request outstanding", out_tdata[0]));
        end else begin
          want = pending_steps.pop_front();
          results_checked++;
          if (out_tdata[0] !== want)
            report_mismatch($sformatf("result %0d: step=%b, predicted %0b",
                                      results_checked, out_tdata[0], want));
          else if (want)
            steps_seen++;
        end
      end
      if (in_tvalid && in_tready)
        pending_steps.push_back(typematic_step(request_t'(in_tdata[dar_pkg::IN_BITS-1:0])));
      if (cfg_we) begin
        case (dar_pkg::cfg_reg_t'(cfg_addr))
          dar_pkg::REG_FIRST_DELAY:  first_delay = cfg_wdata[dar_pkg::DELAY_W-1:0];
          dar_pkg::REG_REPEAT_IVL:   repeat_ivl  = cfg_wdata[dar_pkg::DELAY_W-1:0];
          dar_pkg::REG_PAD_THR:      pad_thr     = cfg_wdata[dar_pkg::THR_W-1:0];
          dar_pkg::REG_PAD_REL_THR:  pad_rel     = cfg_wdata[dar_pkg::THR_W-1:0];
          dar_pkg::REG_PAD2_THR:     pad2_thr    = cfg_wdata[dar_pkg::THR2_W-1:0];
          dar_pkg::REG_PAD2_REL_THR: pad2_rel    = cfg_wdata[dar_pkg::THR2_W-1:0];
          default: ;
        endcase
      end
    end
    steps_waiting = pending_steps.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the direction auto-repeat bench: clock, reset, request stimulus, settings and verdict.
module testbench;

  localparam int LONG_HOLD = 200;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [dar_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [dar_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_we = 1'b0;
  logic [dar_pkg::CFG_ADDR_W-1:0] cfg_addr = dar_pkg::REG_FIRST_DELAY;
  logic [dar_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches, steps_waiting, results_checked, steps_seen;
  int items_sent;
  int send_idle_pct;
  int stall_pct;
  int hold_requests;
  int holds_served;
  int hold_left;

  logic [dar_pkg::DELAY_W-1:0] first_cur    = dar_pkg::FIRST_DELAY_RST;
  logic [dar_pkg::DELAY_W-1:0] repeat_cur   = dar_pkg::REPEAT_IVL_RST;
  logic [dar_pkg::THR_W-1:0]   pad_thr_cur  = dar_pkg::PAD_THR_RST;
  logic [dar_pkg::THR_W-1:0]   pad_rel_cur  = dar_pkg::PAD_REL_THR_RST;
  logic [dar_pkg::THR2_W-1:0]  pad2_thr_cur = dar_pkg::PAD2_THR_RST;
  logic [dar_pkg::THR2_W-1:0]  pad2_rel_cur = dar_pkg::PAD2_REL_THR_RST;
  logic [dar_pkg::FRAME_W-1:0] frame_ctr = 32'd100;
  logic [dar_pkg::TICKS_W-1:0] now_ctr = 64'd5000;

  always #5 clk = ~clk;

  direction_auto_repeat_hysteresis_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  dar_step_checker step_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .steps_waiting   (steps_waiting),
    .results_checked (results_checked),
    .steps_seen      (steps_seen)
  );

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD;
      out_tready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [dar_pkg::IN_DATA_W-1:0] pack_request(
    input logic [dar_pkg::CHAN_W-1:0] chan, input logic [dar_pkg::DIR_W-1:0] dir,
    input bit pressed, input bit held,
    input logic [dar_pkg::STICK_W-1:0] stick, input logic [dar_pkg::STICK2_W-1:0] stick2,
    input logic [dar_pkg::FRAME_W-1:0] frame, input logic [dar_pkg::TICKS_W-1:0] now);
    pack_request = '0;
    pack_request[dar_pkg::IN_BITS-1:0] = {now, frame, stick2, stick, held, pressed, dir, chan};
  endfunction

  function automatic int near_threshold(input int a, input int b);
    int lo, hi;
    lo = ((a < b) ? a : b) - 3;
    hi = ((a < b) ? b : a) + 3;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic offer(input logic [dar_pkg::IN_DATA_W-1:0] req);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // sender pauses until every outstanding result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (steps_waiting == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input dar_pkg::cfg_reg_t r,
                           input logic [dar_pkg::CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] fd, input logic [31:0] rp,
                               input logic [31:0] p, input logic [31:0] pr,
                               input logic [31:0] p2, input logic [31:0] p2r);
    write_reg(dar_pkg::REG_FIRST_DELAY, fd);
    write_reg(dar_pkg::REG_REPEAT_IVL, rp);
    write_reg(dar_pkg::REG_PAD_THR, p);
    write_reg(dar_pkg::REG_PAD_REL_THR, pr);
    write_reg(dar_pkg::REG_PAD2_THR, p2);
    write_reg(dar_pkg::REG_PAD2_REL_THR, p2r);
    cfg_we <= 1'b0;
    @(posedge clk);
    first_cur    = fd;
    repeat_cur   = rp;
    pad_thr_cur  = p[dar_pkg::THR_W-1:0];
    pad_rel_cur  = pr[dar_pkg::THR_W-1:0];
    pad2_thr_cur = p2[dar_pkg::THR2_W-1:0];
    pad2_rel_cur = p2r[dar_pkg::THR2_W-1:0];
  endtask

  // mostly held sequences on one slot with advancing frames and time, some noise
  task automatic run_random(input int n, input int idle_pct, input int stall);
    int sent, len, mode, v;
    logic [dar_pkg::CHAN_W-1:0]   chan;
    logic [dar_pkg::DIR_W-1:0]    dir;
    bit                           pressed, held;
    logic [dar_pkg::STICK_W-1:0]  stick;
    logic [dar_pkg::STICK2_W-1:0] stick2;
    logic [dar_pkg::TICKS_W-1:0]  span;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    sent = 0;
    span = ({32'd0, first_cur} + {32'd0, repeat_cur}) >> 2;
    while (sent < n) begin
      dir = dar_pkg::DIR_W'($urandom_range(3));
      if ($urandom_range(99) < 15) begin
        chan = dar_pkg::CHAN_W'($urandom_range(7));
        offer(pack_request(chan, dir, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           dar_pkg::STICK_W'($urandom), dar_pkg::STICK2_W'($urandom),
                           $urandom, {$urandom, $urandom}));
        sent++;
      end else begin
        chan = ($urandom_range(9) < 8) ? dar_pkg::CHAN_W'($urandom_range(3))
                                       : dar_pkg::CHAN_W'($urandom_range(7, 4));
        mode = $urandom_range(2);
        len  = $urandom_range(12, 3);
        for (int k = 0; k < len && sent < n; k++) begin
          pressed = (k == 0 && mode == 0) ? 1'($urandom_range(1)) : ($urandom_range(19) == 0);
          held    = (mode == 0) ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0);
          v = (mode == 1) ? near_threshold(int'(pad_thr_cur), int'(pad_rel_cur))
                          : int'($urandom_range(20)) - 10;
          stick = v[dar_pkg::STICK_W-1:0];
          v = (mode == 2) ? near_threshold(int'(pad2_thr_cur), int'(pad2_rel_cur))
                          : int'($urandom_range(20)) - 10;
          stick2 = v[dar_pkg::STICK2_W-1:0];
          if (k == 0 || $urandom_range(99) >= 12) frame_ctr++;
          now_ctr += {$urandom, $urandom} % (span + 1);
          offer(pack_request(chan, dir, pressed, held, stick, stick2, frame_ctr, now_ctr));
          sent++;
        end
      end
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first request to an untouched slot with frame all ones hits the reset cache
    offer(pack_request(3'd0, 2'd0, 1'b1, 1'b0, 9'd0, 17'd0, 32'hFFFF_FFFF, 64'd1000));
    offer(pack_request(3'd0, 2'd0, 1'b1, 1'b0, 9'd0, 17'd0, 32'd1, 64'd1000));
    offer(pack_request(3'd0, 2'd0, 1'b0, 1'b0, 9'd0, 17'd0, 32'd1, 64'd1500));
    offer(pack_request(3'd0, 2'd0, 1'b0, 1'b1, 9'd0, 17'd0, 32'd2, 64'd2000));
    offer(pack_request(3'd0, 2'd0, 1'b0, 1'b1, 9'd0, 17'd0, 32'd3, 64'd24301000));
    offer(pack_request(3'd0, 2'd0, 1'b0, 1'b1, 9'd0, 17'd0, 32'd4, 64'd32805999));
    offer(pack_request(3'd0, 2'd0, 1'b0, 1'b1, 9'd0, 17'd0, 32'd5, 64'd32806000));
    // stick hold with hysteresis
    offer(pack_request(3'd1, 2'd1, 1'b0, 1'b0, 9'd51, 17'd0, 32'd6, 64'd100));
    offer(pack_request(3'd1, 2'd1, 1'b0, 1'b0, 9'd36, 17'd0, 32'd7, 64'd200));
    offer(pack_request(3'd1, 2'd1, 1'b0, 1'b0, 9'd35, 17'd0, 32'd8, 64'd300));
    offer(pack_request(3'd1, 2'd1, 1'b0, 1'b0, 9'd40, 17'd0, 32'd9, 64'd400));
    offer(pack_request(3'd2, 2'd2, 1'b0, 1'b0, 9'd0, 17'd21, 32'd10, 64'd500));
    offer(pack_request(3'd2, 2'd2, 1'b0, 1'b0, 9'd0, 17'd15, 32'd11, 64'd600));
    offer(pack_request(3'd3, 2'd3, 1'b0, 1'b0, 9'h100, 17'h10000, 32'd12, 64'd700));
    offer(pack_request(3'd3, 2'd3, 1'b0, 1'b0, 9'd255, 17'd65535, 32'd13, 64'd800));
    // channels 4 to 7 share the last slot
    offer(pack_request(3'd4, 2'd0, 1'b1, 1'b0, 9'd0, 17'd0, 32'd14, 64'd900));
    offer(pack_request(3'd5, 2'd0, 1'b0, 1'b0, 9'd0, 17'd0, 32'd14, 64'd950));
    offer(pack_request(3'd6, 2'd1, 1'b0, 1'b1, 9'd0, 17'd0, 32'd15, 64'd1000));
    offer(pack_request(3'd7, 2'd1, 1'b0, 1'b0, 9'd0, 17'd0, 32'd15, 64'd1050));
    // due time wraps past the top of the tick counter
    offer(pack_request(3'd0, 2'd1, 1'b1, 1'b0, 9'd0, 17'd0, 32'd16, 64'hFFFF_FFFF_FFFF_FFFF));
    offer(pack_request(3'd0, 2'd1, 1'b0, 1'b1, 9'd0, 17'd0, 32'd17, 64'd0));
    offer(pack_request(3'd0, 2'd1, 1'b0, 1'b1, 9'd0, 17'd0, 32'd18, 64'd24299999));
    offer(pack_request(3'd2, 2'd0, 1'b0, 1'b0, 9'd128, 17'd32768, 32'd19, 64'd1100));
    offer(pack_request(3'd3, 2'd0, 1'b1, 1'b1, 9'h181, 17'h18001, 32'd20, 64'd1200));
    drain();

    run_random(150, 0, 0);
    apply_setting(32'd40, 32'd15, 32'd60, 32'd30, 32'd1000, 32'd500);
    run_random(150, 87, 0);
    apply_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_random(150, 0, 87);
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255, 32'd128, 32'd65535, 32'd32768);
    now_ctr = 64'hFFFF_FFFF_0000_0000;
    run_random(150, 19, 19);
    apply_setting(32'd100, 32'd1, 32'd128, 32'd0, 32'd32768, 32'd14);
    hold_requests <= hold_requests + 1;
    run_random(60, 0, 0);
    run_random(100, 19, 19);
    apply_setting(32'd7, 32'd3, 32'd50, 32'd35, 32'd20, 32'd14);
    run_random(120, 0, 0);

    repeat (8) @(posedge clk);
    $display("Covered %0d requests under six register settings, with idle, stall and hold-off.",
             items_sent);
    $display("%0d results compared, %0d of them steps.", results_checked, steps_seen);
    if (mismatches == 0 && steps_waiting == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== direction_auto_repeat_hysteresis_top.f =====
hdl/dar_pkg.sv
hdl/direction_auto_repeat_hysteresis_top.sv
bench/dar_step_checker.sv
bench/testbench.sv
